### src/lru_key_cache_defines.svh
// ----------------------------------------------------------------------------
// LRU key cache assertion macros
// Shared assertion shorthands for the LRU key cache RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_CACHE_DEFINES_SVH
`define LRU_KEY_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru_key_cache: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru_key_cache: next-cycle check failed");

`endif

### src/lkc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key cache package
// Sizes, controller states and the command bundle shared by the cache modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkc_pkg;

  localparam int CAPACITY = 8;
  localparam int KEY_W    = 64;
  localparam int TOTAL_W  = 64;
  localparam int SLOT_W   = 3;
  localparam int OCC_W    = 4;

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Rank held by the least recent entry once every slot is valid.
  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } lkc_state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } lkc_cmd_t;

endpackage

`default_nettype wire

### src/lkc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key cache controller
// Sequences each request through capture, lookup and update steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  output logic                  done,
  output lkc_pkg::lkc_cmd_t     cmd
);

  import lkc_pkg::*;

  lkc_state_t state;
  lkc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_UPDATE);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_LOOKUP;
      end
      S_LOOKUP: state_next = S_UPDATE;
      S_UPDATE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.update  = 1'b0;
    case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_LOOKUP: cmd.lookup = 1'b1;
      S_UPDATE: cmd.update = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

### src/lkc_datapath.sv
// ----------------------------------------------------------------------------
// LRU key cache datapath
// Key store, parallel match, recency ranks, counters and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_cache_defines.svh"

module lkc_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lkc_pkg::lkc_cmd_t              cmd,
  input  wire logic signed [lkc_pkg::KEY_W-1:0] key_group_0,
  input  wire logic signed [lkc_pkg::KEY_W-1:0] key_group_1,
  input  wire logic signed [lkc_pkg::KEY_W-1:0] key_group_2,
  input  wire logic signed [lkc_pkg::KEY_W-1:0] key_group_3,
  output logic                                hit,
  output logic [lkc_pkg::SLOT_W-1:0]          slot,
  output logic                                evicted,
  output logic [lkc_pkg::OCC_W-1:0]           occupancy,
  output logic [lkc_pkg::TOTAL_W-1:0]         built_count,
  output logic [lkc_pkg::TOTAL_W-1:0]         eviction_count
);

  import lkc_pkg::*;

  // Captured request key.
  logic [KEY_W-1:0] key_a;
  logic [KEY_W-1:0] key_b;
  logic [KEY_W-1:0] key_c;
  logic [KEY_W-1:0] key_d;

  // Entry storage: keys carry no reset, validity and ranks do.
  logic [KEY_W-1:0]  store_a [CAPACITY];
  logic [KEY_W-1:0]  store_b [CAPACITY];
  logic [KEY_W-1:0]  store_c [CAPACITY];
  logic [KEY_W-1:0]  store_d [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [RANK_W-1:0] rank [CAPACITY];
  logic [CNT_W-1:0]  valid_total;
  logic [TOTAL_W-1:0] miss_total;
  logic [TOTAL_W-1:0] evict_total;

  // Lookup results, registered between the lookup and update steps.
  logic              lk_hit;
  logic              lk_evict;
  logic [IDX_W-1:0]  lk_idx;
  logic [RANK_W-1:0] lk_rank;

  logic [CAPACITY-1:0] match;
  logic [IDX_W-1:0]    found_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    victim_idx;
  logic                full;

  logic [CNT_W-1:0]   valid_total_next;
  logic [TOTAL_W-1:0] miss_total_next;
  logic [TOTAL_W-1:0] evict_total_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_a <= key_group_0;
      key_b <= key_group_1;
      key_c <= key_group_2;
      key_d <= key_group_3;
    end
  end

  // Every entry is compared at once; the lowest matching slot wins.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid[i] && (store_a[i] == key_a) && (store_b[i] == key_b) &&
                 (store_c[i] == key_c) && (store_d[i] == key_d);
    end
  end

  always_comb begin
    found_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) found_idx = IDX_W'(i);
      if (!valid[i]) free_idx = IDX_W'(i);
      if (valid[i] && (rank[i] == LAST_RANK)) victim_idx = IDX_W'(i);
    end
  end

  assign full = &valid;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      lk_hit   <= |match;
      lk_evict <= !(|match) && full;
      lk_rank  <= rank[found_idx];
      if (|match) begin
        lk_idx <= found_idx;
      end else if (full) begin
        lk_idx <= victim_idx;
      end else begin
        lk_idx <= free_idx;
      end
    end
  end

  // Occupancy only grows on a miss that found a free slot.
  always_comb begin
    valid_total_next = valid_total;
    if (!lk_hit && !lk_evict) valid_total_next = valid_total + CNT_W'(1);
    miss_total_next = miss_total;
    if (!lk_hit && (miss_total != '1)) miss_total_next = miss_total + TOTAL_W'(1);
    evict_total_next = evict_total;
    if (lk_evict && (evict_total != '1)) evict_total_next = evict_total + TOTAL_W'(1);
  end

  // The chosen slot becomes the most recent; on a hit only the entries that
  // were more recent than it age, on a miss every other valid entry ages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      valid_total <= '0;
      miss_total  <= '0;
      evict_total <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (IDX_W'(i) == lk_idx) begin
          rank[i] <= '0;
        end else if (lk_hit) begin
          if (valid[i] && (rank[i] < lk_rank)) rank[i] <= rank[i] + RANK_W'(1);
        end else if (valid[i]) begin
          rank[i] <= rank[i] + RANK_W'(1);
        end
      end
      valid[lk_idx] <= 1'b1;
      valid_total   <= valid_total_next;
      miss_total    <= miss_total_next;
      evict_total   <= evict_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !lk_hit) begin
      store_a[lk_idx] <= key_a;
      store_b[lk_idx] <= key_b;
      store_c[lk_idx] <= key_c;
      store_d[lk_idx] <= key_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit            <= lk_hit;
      slot           <= SLOT_W'(lk_idx);
      evicted        <= lk_evict;
      occupancy      <= OCC_W'(valid_total_next);
      built_count    <= miss_total_next;
      eviction_count <= evict_total_next;
    end
  end

  `LKC_ASSERT_IMP(a_count_tracks_valid, clk, rst, 1'b1, valid_total == CNT_W'($countones(valid)))
  `LKC_ASSERT_IMP(a_evict_only_full, clk, rst, cmd.update && lk_evict, full && !lk_hit)
  `LKC_ASSERT_NEXT(a_hit_keeps_count, clk, rst, cmd.update && lk_hit, valid_total == $past(valid_total))
  `LKC_ASSERT_NEXT(a_update_marks_mru, clk, rst, cmd.update, valid[lk_idx] && (rank[lk_idx] == '0))

endmodule

`default_nettype wire

### src/lru_key_cache.sv
// ----------------------------------------------------------------------------
// LRU key cache
// Fully associative least-recently-used store of four-group 64-bit keys.
// ----------------------------------------------------------------------------
// Result: the done strobe rises after the capture, lookup and update steps,
// and the result is taken at the edge that ends the strobe.
// Requests: a new request is taken only once the controller's capture, lookup
// and update sequence around the single key store has finished.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset clears validity, ranks, occupancy and both counters; keys are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_key_cache (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [lkc_pkg::KEY_W-1:0] key_group_0,
  input  wire logic signed [lkc_pkg::KEY_W-1:0] key_group_1,
  input  wire logic signed [lkc_pkg::KEY_W-1:0] key_group_2,
  input  wire logic signed [lkc_pkg::KEY_W-1:0] key_group_3,
  output logic                                done,
  output logic                                hit,
  output logic [lkc_pkg::SLOT_W-1:0]          slot,
  output logic                                evicted,
  output logic [lkc_pkg::OCC_W-1:0]           occupancy,
  output logic [lkc_pkg::TOTAL_W-1:0]         built_count,
  output logic [lkc_pkg::TOTAL_W-1:0]         eviction_count
);

  import lkc_pkg::*;

  // Command bundle from the controller to the datapath. Only one step is
  // active in any cycle: capture on the accepting edge, then lookup, then
  // update, after which the result registers hold the finished transfer.
  lkc_cmd_t cmd;

  // The controller owns the handshake. A start transfer is taken whenever it
  // is idle, including the cycle in which the previous result is strobed,
  // because the result lives in its own registers in the datapath.
  lkc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // The datapath compares the captured key against every valid entry in
  // parallel, picks a hit, a free slot or the least recent victim, and then
  // rewrites ranks, storage and the saturating counters in the update step.
  lkc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .key_group_0    (key_group_0),
    .key_group_1    (key_group_1),
    .key_group_2    (key_group_2),
    .key_group_3    (key_group_3),
    .hit            (hit),
    .slot           (slot),
    .evicted        (evicted),
    .occupancy      (occupancy),
    .built_count    (built_count),
    .eviction_count (eviction_count)
  );

endmodule

`default_nettype wire
